[design/fct_pkg.sv]
// Shared types and constants of the frustum cull test.
`default_nettype none

package fct_pkg;

    localparam int PLANE_REGS   = 6;
    localparam int NORM_BITS    = 16;
    localparam int PLANE_BITS   = 64;
    localparam int RADIUS_BITS  = 15;
    localparam int FRAC_SHIFT   = 14;
    localparam int ROUND_BIAS   = 8192;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRUSTUM_VALID = 3'd6;

    typedef enum logic [1:0] {
        OP_POINT    = 2'd0,
        OP_SPHERE   = 2'd1,
        OP_BOX      = 2'd2,
        OP_RESERVED = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        VERDICT_INSIDE  = 2'd0,
        VERDICT_PARTIAL = 2'd1,
        VERDICT_OUTSIDE = 2'd2
    } t_verdict;

    typedef struct packed {
        logic adv_b;
        logic adv_c;
    } t_stage_en;

endpackage

`default_nettype wire

[design/fct_lane.sv]
// One plane lane: corner selection, products, rounded signed distance.
`default_nettype none

module fct_lane import fct_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int DIST_BITS  = 34
) (
    input  wire logic                          i_clk,
    input  wire t_stage_en                     i_adv,
    input  wire logic [PLANE_BITS-1:0]         i_plane,
    input  wire logic                          i_box,
    input  wire logic signed [COORD_BITS-1:0]  i_mn [3],
    input  wire logic signed [COORD_BITS-1:0]  i_mx [3],
    output logic signed [DIST_BITS-1:0]        o_dist_far,
    output logic signed [DIST_BITS-1:0]        o_dist_near
);

    localparam int PW = COORD_BITS + NORM_BITS;

    logic signed [NORM_BITS-1:0]  w_n [3];
    logic signed [NORM_BITS-1:0]  w_off;
    logic signed [COORD_BITS-1:0] w_far [3];
    logic signed [COORD_BITS-1:0] w_near [3];
    logic signed [PW-1:0]         n_pf [3];
    logic signed [PW-1:0]         n_pn [3];
    logic signed [PW-1:0]         r_pf [3];
    logic signed [PW-1:0]         r_pn [3];
    logic signed [DIST_BITS-1:0]  w_bias;
    logic signed [DIST_BITS-1:0]  w_acc_far;
    logic signed [DIST_BITS-1:0]  w_acc_near;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_n[a]    = i_plane[NORM_BITS*a +: NORM_BITS];
            w_far[a]  = (i_box && !w_n[a][NORM_BITS-1]) ? i_mx[a] : i_mn[a];
            w_near[a] = (i_box &&  w_n[a][NORM_BITS-1]) ? i_mx[a] : i_mn[a];
            n_pf[a]   = PW'(w_far[a])  * PW'(w_n[a]);
            n_pn[a]   = PW'(w_near[a]) * PW'(w_n[a]);
        end
        w_off = i_plane[PLANE_BITS-1 -: NORM_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.adv_b) begin
            r_pf <= n_pf;
            r_pn <= n_pn;
        end
    end

    // fold rounding and offset into one sum ahead of the floor shift
    assign w_bias = DIST_BITS'(ROUND_BIAS) - (DIST_BITS'(w_off) <<< FRAC_SHIFT);

    assign w_acc_far  = DIST_BITS'(r_pf[0]) + DIST_BITS'(r_pf[1])
                      + DIST_BITS'(r_pf[2]) + w_bias;
    assign w_acc_near = DIST_BITS'(r_pn[0]) + DIST_BITS'(r_pn[1])
                      + DIST_BITS'(r_pn[2]) + w_bias;

    always_ff @(posedge i_clk) begin
        if (i_adv.adv_c) begin
            o_dist_far  <= w_acc_far  >>> FRAC_SHIFT;
            o_dist_near <= w_acc_near >>> FRAC_SHIFT;
        end
    end

endmodule

`default_nettype wire

[design/fct_verdict.sv]
// Per-plane compare and reduction to one verdict.
`default_nettype none

module fct_verdict import fct_pkg::*; #(
    parameter int PLANES    = 6,
    parameter int DIST_BITS = 34
) (
    input  wire t_opcode                      i_op,
    input  wire logic [RADIUS_BITS-1:0]       i_radius,
    input  wire logic                         i_enable,
    input  wire logic signed [DIST_BITS-1:0]  i_dist_far [PLANES],
    input  wire logic signed [DIST_BITS-1:0]  i_dist_near [PLANES],
    output t_verdict                          o_verdict
);

    logic signed [DIST_BITS-1:0] w_rad;
    logic signed [DIST_BITS-1:0] w_neg_rad;
    logic [PLANES-1:0]           w_out;
    logic [PLANES-1:0]           w_part;

    assign w_rad     = DIST_BITS'($signed({1'b0, i_radius}));
    assign w_neg_rad = -w_rad;

    always_comb begin
        for (int k = 0; k < PLANES; k++) begin
            case (i_op)
                OP_POINT: begin
                    w_out[k]  = i_dist_far[k] < 0;
                    w_part[k] = 1'b0;
                end
                OP_SPHERE: begin
                    w_out[k]  = i_dist_far[k] < w_neg_rad;
                    w_part[k] = i_dist_far[k] < w_rad;
                end
                OP_BOX: begin
                    w_out[k]  = i_dist_far[k] < 0;
                    w_part[k] = i_dist_near[k] < 0;
                end
                default: begin
                    w_out[k]  = 1'b0;
                    w_part[k] = 1'b0;
                end
            endcase
        end
        if (!i_enable) begin
            o_verdict = VERDICT_INSIDE;
        end else if (|w_out) begin
            o_verdict = VERDICT_OUTSIDE;
        end else if (|w_part) begin
            o_verdict = VERDICT_PARTIAL;
        end else begin
            o_verdict = VERDICT_INSIDE;
        end
    end

endmodule

`default_nettype wire

[design/frustum_cull_test.sv]
// Top level of the frustum cull test: handshakes, plane registers, pipeline.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------
//  input   | in        | i_in_valid / o_in_ready    | opcode, pos_x/y/z, max_x/y/z, radius
//  result  | out       | o_out_valid / i_out_ready  | verdict
//  config  | in        | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
// One transaction per cycle unless the output stalls; four register stages: input
// register, product register, distance register, verdict register. An accepted
// transaction passes through them in that order, its result valid in the verdict
// register. Each stage holds only while the stage after it is full and stalled, so
// bubbles fill under a stalled output. Synchronous active-low reset clears all valid
// bits and plane registers. Configuration writes complete in the cycle they are offered.
`default_nettype none

module frustum_cull_test import fct_pkg::*; #(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic signed [COORD_BITS-1:0]  i_pos_x,
    input  wire logic signed [COORD_BITS-1:0]  i_pos_y,
    input  wire logic signed [COORD_BITS-1:0]  i_pos_z,
    input  wire logic signed [COORD_BITS-1:0]  i_max_x,
    input  wire logic signed [COORD_BITS-1:0]  i_max_y,
    input  wire logic signed [COORD_BITS-1:0]  i_max_z,
    input  wire logic [RADIUS_BITS-1:0]        i_radius,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_verdict,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire logic [PLANE_BITS-1:0]         i_cfg_data
);

    localparam int NP = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;
    localparam int DW = (COORD_BITS + 18 > 32) ? COORD_BITS + 18 : 32;

    logic [PLANE_BITS-1:0]         r_plane [PLANE_REGS];
    logic                          r_frustum_valid;

    logic                          r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic                          w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;
    t_stage_en                     w_adv;

    t_opcode                       r_a_op, r_b_op, r_c_op;
    logic [RADIUS_BITS-1:0]        r_a_rad, r_b_rad, r_c_rad;
    logic signed [COORD_BITS-1:0]  r_a_mn [3];
    logic signed [COORD_BITS-1:0]  r_a_mx [3];
    logic signed [DW-1:0]          w_dist_far [NP];
    logic signed [DW-1:0]          w_dist_near [NP];
    t_verdict                      n_verdict;
    t_verdict                      r_verdict;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PLANE_REGS; k++) begin
                r_plane[k] <= '0;
            end
            r_frustum_valid <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_FRUSTUM_VALID) begin
                r_frustum_valid <= i_cfg_data[0];
            end else if (i_cfg_index < CFG_FRUSTUM_VALID) begin
                r_plane[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    assign w_rdy_d    = !r_d_vld || i_out_ready;
    assign w_rdy_c    = !r_c_vld || w_rdy_d;
    assign w_rdy_b    = !r_b_vld || w_rdy_c;
    assign w_rdy_a    = !r_a_vld || w_rdy_b;
    assign o_in_ready = w_rdy_a;
    assign w_adv      = '{adv_b: w_rdy_b, adv_c: w_rdy_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (w_rdy_a) r_a_vld <= i_in_valid;
            if (w_rdy_b) r_b_vld <= r_a_vld;
            if (w_rdy_c) r_c_vld <= r_b_vld;
            if (w_rdy_d) r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_op    <= t_opcode'(i_opcode);
            r_a_rad   <= i_radius;
            r_a_mn[0] <= i_pos_x;
            r_a_mn[1] <= i_pos_y;
            r_a_mn[2] <= i_pos_z;
            r_a_mx[0] <= i_max_x;
            r_a_mx[1] <= i_max_y;
            r_a_mx[2] <= i_max_z;
        end
        if (w_rdy_b) begin
            r_b_op  <= r_a_op;
            r_b_rad <= r_a_rad;
        end
        if (w_rdy_c) begin
            r_c_op  <= r_b_op;
            r_c_rad <= r_b_rad;
        end
        if (w_rdy_d) begin
            r_verdict <= n_verdict;
        end
    end

    for (genvar k = 0; k < NP; k++) begin : g_lane
        fct_lane #(
            .COORD_BITS (COORD_BITS),
            .DIST_BITS  (DW)
        ) u_fct_lane (
            .i_clk       (i_clk),
            .i_adv       (w_adv),
            .i_plane     (r_plane[k]),
            .i_box       (r_a_op == OP_BOX),
            .i_mn        (r_a_mn),
            .i_mx        (r_a_mx),
            .o_dist_far  (w_dist_far[k]),
            .o_dist_near (w_dist_near[k])
        );
    end

    fct_verdict #(
        .PLANES    (NP),
        .DIST_BITS (DW)
    ) u_fct_verdict (
        .i_op        (r_c_op),
        .i_radius    (r_c_rad),
        .i_enable    (r_frustum_valid),
        .i_dist_far  (w_dist_far),
        .i_dist_near (w_dist_near),
        .o_verdict   (n_verdict)
    );

    assign o_out_valid = r_d_vld;
    assign o_verdict   = r_verdict;

endmodule

`default_nettype wire

[design/fct_checker.sv]
// Port-level checks of the frustum cull test and their binding.
`default_nettype none

module fct_checker import fct_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       o_in_ready,
    input  wire logic       o_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [1:0] o_verdict,
    input  wire logic       o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict))
        else $error("stalled result changed or dropped");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict == VERDICT_INSIDE || o_verdict == VERDICT_PARTIAL
                         || o_verdict == VERDICT_OUTSIDE))
        else $error("result carries a reserved verdict code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready && o_cfg_ready)
        else $error("pipeline not empty after reset");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (.*);

`default_nettype wire
